@@ hw/rtl/ght_pkg.sv @@
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants for the generational handle table
// Request and response structs, operation and status codes, the queue entry
// and the back-end sequencer states.
// ----------------------------------------------------------------------------
package ght_pkg;

	// Default sizing
	localparam int SLOT_COUNT_DEF = 256;
	localparam int GEN_BITS_DEF   = 32;

	// Request kind codes as they arrive on the port
	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_DESTROY = 2'd1;
	localparam logic [1:0] KIND_CHECK   = 2'd2;
	// spare code, treated as check
	localparam logic [1:0] KIND_SPARE   = 2'd3;

	// Response status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	// Request transfer
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  handle_index;
		logic [31:0] handle_generation;
	} req_item_t;

	// Response transfer
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  slot_index;
		logic [31:0] slot_generation;
	} rsp_item_t;

	// Classified operation
	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_DESTROY,
		OP_CHECK
	} op_t;

	// Queue entry between front and back
	typedef struct packed {
		op_t         op;
		logic [7:0]  index;
		logic [31:0] generation;
	} op_item_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_READ
	} back_state_t;

endpackage

@@ hw/rtl/generational_handle_table_top.sv @@
// ----------------------------------------------------------------------------
// generational_handle_table_top: generational handle table
// Slot map with per-slot generation and live mark, handing out handles,
// retiring them and checking them.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): allocate, destroy or check.
//   Response channel (rsp_valid / rsp_stall / rsp): one response per request,
//   in request order. A transfer happens when valid is high and stall is low.
//   A two-entry queue takes requests while the back end works or the response
//   register waits on rsp_stall; req_stall rises once both entries are full.
// Response path, queue empty and response register free:
//   table full, never-used index and fresh allocation are answered straight
//   from the idle state; check and destroy first read the slot memory, and
//   a valid destroy then writes it back; allocation from the free stack reads
//   the stack, then the slot, then writes the slot back.
// The back end works on one request at a time: it takes the next one from
//   the queue only when idle and the response register is free.
// Reset: counts clear at once; slot entries are written on first allocation
//   before they are ever read, so no memory clearing pass is needed and
//   requests are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module generational_handle_table_top import ght_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int GEN_BITS   = GEN_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	logic     q_valid;
	logic     q_pop;
	op_item_t q_data;

	// Intake and queue
	ght_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data)
	);

	// Execution
	ght_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.GEN_BITS   (GEN_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_data    (q_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

@@ hw/rtl/ght_front.sv @@
// ----------------------------------------------------------------------------
// ght_front: request intake
// Accepts request transfers, decodes the kind into an operation and holds
// them in a two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
module ght_front import ght_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      q_valid,
	input  logic      q_pop,
	output op_item_t  q_data
);

	op_item_t   ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	op_item_t   cls;

	// Classify: unused kind behaves as check
	always_comb begin
		cls.index      = req.handle_index;
		cls.generation = req.handle_generation;
		case (req.kind)
			KIND_ALLOC:   cls.op = OP_ALLOC;
			KIND_DESTROY: cls.op = OP_DESTROY;
			default:      cls.op = OP_CHECK;
		endcase
	end

	assign req_stall = (count_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign q_valid   = (count_q != 2'd0);
	assign q_data    = ent_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/ght_back.sv @@
// ----------------------------------------------------------------------------
// ght_back: operation execution
// Sequencer over the slot memory (generation plus live mark) and the free
// stack memory; an operation reads the slot when it needs it, writes it back
// for a valid destroy and for stack allocation, and loads the response register.
// ----------------------------------------------------------------------------
module ght_back import ght_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int GEN_BITS   = GEN_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	output logic      q_pop,
	input  op_item_t  q_data,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	// Slot memory word: live mark above the generation
	logic [GEN_BITS:0] slot_mem [SLOT_COUNT];
	logic [IDX_W-1:0]  stack_mem [SLOT_COUNT];

	back_state_t       state_q, state_d;
	op_item_t          op_q;
	logic [IDX_W-1:0]  slot_q;
	logic [CNT_W-1:0]  used_cnt_q;
	logic [CNT_W-1:0]  free_cnt_q;
	logic              rsp_valid_q;
	rsp_item_t         rsp_q;

	logic [GEN_BITS:0] slot_rd_q;
	logic [IDX_W-1:0]  stack_rd_q;

	logic              out_free;
	logic              in_range;
	logic              free_avail;
	logic              used_avail;
	logic              stack_room;
	logic [GEN_BITS-1:0] cur_gen;
	logic [GEN_BITS-1:0] next_gen;
	logic              cur_live;
	logic              handle_ok;

	logic              slot_we, slot_re;
	logic [IDX_W-1:0]  slot_waddr, slot_raddr;
	logic [GEN_BITS:0] slot_wdata;
	logic              stack_we, stack_re;
	logic [IDX_W-1:0]  stack_waddr, stack_raddr;
	logic              used_inc, free_dec, free_inc;
	logic              rsp_load;
	rsp_item_t         rsp_d;

	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign in_range   = (32'(q_data.index) < 32'(used_cnt_q));
	assign free_avail = (free_cnt_q != '0);
	assign used_avail = (used_cnt_q < CNT_W'(SLOT_COUNT));
	assign stack_room = (free_cnt_q < CNT_W'(SLOT_COUNT));
	assign cur_gen    = slot_rd_q[GEN_BITS-1:0];
	assign cur_live   = slot_rd_q[GEN_BITS];
	assign next_gen   = cur_gen + GEN_BITS'(1);
	assign handle_ok  = cur_live && (32'(cur_gen) == op_q.generation);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid && out_free) begin
					if (q_data.op == OP_ALLOC) begin
						if (free_avail) begin
							state_d = S_POP;
						end
					end else if (in_range) begin
						state_d = S_READ;
					end
				end
			end
			S_POP:   state_d = S_READ;
			S_READ:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		q_pop       = 1'b0;
		slot_we     = 1'b0;
		slot_re     = 1'b0;
		slot_waddr  = IDX_W'(op_q.index);
		slot_raddr  = IDX_W'(q_data.index);
		slot_wdata  = {1'b0, next_gen};
		stack_we    = 1'b0;
		stack_re    = 1'b0;
		stack_waddr = IDX_W'(free_cnt_q);
		stack_raddr = IDX_W'(free_cnt_q - CNT_W'(1));
		used_inc    = 1'b0;
		free_dec    = 1'b0;
		free_inc    = 1'b0;
		rsp_load    = 1'b0;
		rsp_d       = '{status: STATUS_INVALID, slot_index: q_data.index,
			slot_generation: 32'd0};
		case (state_q)
			S_IDLE: begin
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_data.op == OP_ALLOC) begin
						if (free_avail) begin
							stack_re = 1'b1;
						end else if (used_avail) begin
							// fresh slot, generation starts at one
							slot_we    = 1'b1;
							slot_waddr = IDX_W'(used_cnt_q);
							slot_wdata = {1'b1, GEN_BITS'(1)};
							used_inc   = 1'b1;
							rsp_load   = 1'b1;
							rsp_d      = '{status: STATUS_OK,
								slot_index: 8'(used_cnt_q),
								slot_generation: 32'(GEN_BITS'(1))};
						end else begin
							rsp_load = 1'b1;
							rsp_d    = '{status: STATUS_FULL, slot_index: 8'd0,
								slot_generation: 32'd0};
						end
					end else if (in_range) begin
						slot_re = 1'b1;
					end else begin
						// index never used
						rsp_load = 1'b1;
					end
				end
			end
			S_POP: begin
				free_dec   = 1'b1;
				slot_re    = 1'b1;
				slot_raddr = stack_rd_q;
			end
			S_READ: begin
				rsp_load = 1'b1;
				case (op_q.op)
					OP_ALLOC: begin
						slot_we    = 1'b1;
						slot_waddr = slot_q;
						slot_wdata = {1'b1, cur_gen};
						rsp_d      = '{status: STATUS_OK, slot_index: 8'(slot_q),
							slot_generation: 32'(cur_gen)};
					end
					OP_DESTROY: begin
						if (handle_ok) begin
							slot_we     = 1'b1;
							stack_we    = stack_room;
							free_inc    = stack_room;
							rsp_d       = '{status: STATUS_OK, slot_index: op_q.index,
								slot_generation: 32'(next_gen)};
						end else begin
							rsp_d = '{status: STATUS_INVALID, slot_index: op_q.index,
								slot_generation: 32'(cur_gen)};
						end
					end
					default: begin
						rsp_d = '{status: handle_ok ? STATUS_OK : STATUS_INVALID,
							slot_index: op_q.index, slot_generation: 32'(cur_gen)};
					end
				endcase
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	// Slot memory
	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	// Free stack memory
	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= IDX_W'(op_q.index);
		end
		if (stack_re) begin
			stack_rd_q <= stack_mem[stack_raddr];
		end
	end

	// Operation and slot holding, response payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_data;
		end
		if (state_q == S_POP) begin
			slot_q <= stack_rd_q;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_cnt_q  <= '0;
			free_cnt_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (used_inc) begin
				used_cnt_q <= used_cnt_q + CNT_W'(1);
			end
			if (free_dec) begin
				free_cnt_q <= free_cnt_q - CNT_W'(1);
			end else if (free_inc) begin
				free_cnt_q <= free_cnt_q + CNT_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
